>>> design/fti_pkg.sv
package fti_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int PRICE_BITS_DEF   = 32;
    localparam int PERIOD_BITS      = 7;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 7'd10;

    // log2 result: signed exponent over 30 fraction bits
    localparam int LOG_W = 36;

    localparam logic signed [31:0] K_066      = 32'sd708669604;
    localparam logic signed [31:0] K_067      = 32'sd719407022;
    localparam logic signed [31:0] K_099      = 32'sd1063004406;
    localparam logic signed [31:0] K_0999     = 32'sd1072668082;
    localparam logic signed [31:0] K_HALF_LN2 = 32'sd372130559;
    localparam logic signed [31:0] Q30_ONE    = 32'sd1073741824;
    localparam logic signed [31:0] Q30_HALF   = 32'sd536870912;

    typedef struct packed {
        logic [31:0] high_price;
        logic [31:0] low_price;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] fisher_value;
        logic signed [31:0] signal_value;
    } out_item_t;

endpackage

>>> design/fti_ram.sv
module fti_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/fti_log2.sv
module fti_log2 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [30:0]                      operand,
    output logic                             busy,
    output logic signed [fti_pkg::LOG_W-1:0] result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NORM = 2'd1;
    localparam logic [1:0] ST_SQR  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [30:0]       m_reg, m_next;
    logic signed [5:0] e_reg, e_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [29:0]       frac_reg, frac_next;
    logic [61:0]       sq;
    logic [31:0]       t;

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        cnt_next   = cnt_reg;
        frac_next  = frac_reg;
        sq         = 62'(m_reg) * 62'(m_reg);
        t          = sq[61:30];
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    m_next     = (operand == 31'd0) ? 31'd1 : operand;
                    e_next     = 6'sd0;
                    frac_next  = 30'd0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (!m_reg[30])
                begin
                    m_next = {m_reg[29:0], 1'b0};
                    e_next = e_reg - 6'sd1;
                end
                else
                begin
                    cnt_next   = 5'd29;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (t[31])
                begin
                    m_next            = t[31:1];
                    frac_next[cnt_reg] = 1'b1;
                end
                else
                begin
                    m_next = t[30:0];
                end
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        e_reg    <= e_next;
        cnt_reg  <= cnt_next;
        frac_reg <= frac_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign result = $signed({e_reg, frac_reg});

endmodule

>>> design/fisher_transform_indicator_top.sv
// Ehlers Fisher transform over high/low price bars. Each beat carries one bar;
// the sum high+low goes into a window RAM, the scan spans the last period
// entries, and once period bars are in, every bar gives one beat of
// fisher_value and signal_value (the previous fisher value), both signed Q4.27.
// Warm-up bars are only written to the window. For a bar with a result, the
// window scan reads one RAM entry per cycle, the ratio comes from a restoring
// divider that is skipped when every scanned entry is equal, and two log2 units
// run side by side, each normalizing and then taking 30 squaring steps on one
// 31x31 multiplier; smoothing and the final scale follow, and the result beat
// waits while the output is stalled. The input stalls while a bar is in
// progress. period is to be written only while idle; the block does not enforce
// this. Zero acts as 1 and values above the window depth act as the depth.
module fisher_transform_indicator_top #(
    parameter int WINDOW_DEPTH = fti_pkg::WINDOW_DEPTH_DEF,
    parameter int PRICE_BITS   = fti_pkg::PRICE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [fti_pkg::PERIOD_BITS-1:0]  cfg_write_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  fti_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output fti_pkg::out_item_t               out_data
);

    localparam int W  = PRICE_BITS + 1;
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int XW = CW + 1;
    localparam logic [31:0] PMASK =
        (PRICE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << PRICE_BITS) - 64'd1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SCAN = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_SMTH = 4'd4;
    localparam logic [3:0] ST_LOGW = 4'd5;
    localparam logic [3:0] ST_FIN  = 4'd6;
    localparam logic [3:0] ST_OUT  = 4'd7;

    logic [3:0]                      state_reg, state_next;
    logic [fti_pkg::PERIOD_BITS-1:0] period_reg, period_next;
    logic [AW-1:0]                   wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   p_reg, p_next;
    logic [CW-1:0]                   k_reg, k_next;
    logic                            pend_reg, pend_next;
    logic [W-1:0]                    sum_reg, sum_next;
    logic [W-1:0]                    max_reg, max_next;
    logic [W-1:0]                    min_reg, min_next;
    logic [W-1:0]                    range_reg, range_next;
    logic [W-1:0]                    rem_reg, rem_next;
    logic [30:0]                     q_reg, q_next;
    logic [4:0]                      div_cnt_reg, div_cnt_next;
    logic signed [63:0]              pa_reg, pa_next;
    logic signed [63:0]              pb_reg, pb_next;
    logic signed [31:0]              smooth_reg, smooth_next;
    logic signed [63:0]              prod_reg, prod_next;
    logic signed [31:0]              fish_reg, fish_next;
    logic signed [31:0]              fprev_reg, fprev_next;
    logic                            out_valid_reg, out_valid_next;
    fti_pkg::out_item_t              out_data_reg, out_data_next;

    logic                            accept;
    logic [31:0]                     hp_m, lp_m;
    logic [W-1:0]                    sum_in;
    logic [CW-1:0]                   count_inc;
    logic [CW-1:0]                   p_eff;
    logic [XW-1:0]                   addr_wide;
    logic [AW-1:0]                   rd_addr;
    logic [W-1:0]                    rd_data;
    logic [W-1:0]                    range_w, num_w;
    logic [W:0]                      rem_sh;
    logic signed [31:0]              qd;
    logic signed [63:0]              vsum, vsh;
    logic signed [31:0]              vc;
    logic signed [63:0]              opa_w, opb_w;
    logic                            log_start;
    logic [30:0]                     opa, opb;
    logic                            busy_a, busy_b;
    logic signed [fti_pkg::LOG_W-1:0] la, lb;
    logic signed [fti_pkg::LOG_W:0]  d;
    logic signed [63:0]              at_w;
    logic signed [32:0]              half_w;
    logic signed [32:0]              fish_w;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign hp_m     = in_data.high_price & PMASK;
    assign lp_m     = in_data.low_price & PMASK;
    assign sum_in   = W'(hp_m) + W'(lp_m);

    // window entry k bars back from the newest
    always_comb
    begin
        addr_wide = XW'(wr_ptr_reg) + XW'(WINDOW_DEPTH) - XW'(k_reg);
        if (addr_wide >= XW'(WINDOW_DEPTH))
        begin
            addr_wide = addr_wide - XW'(WINDOW_DEPTH);
        end
        rd_addr = AW'(addr_wide);
    end

    fti_ram #(
        .WIDTH (W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (accept),
        .waddr (wr_ptr_reg),
        .wdata (sum_in),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    fti_log2 u_log_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (log_start),
        .operand (opa),
        .busy    (busy_a),
        .result  (la)
    );

    fti_log2 u_log_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (log_start),
        .operand (opb),
        .busy    (busy_b),
        .result  (lb)
    );

    always_comb
    begin
        if (period_reg == '0)
        begin
            p_eff = CW'(1);
        end
        else if (32'(period_reg) > WINDOW_DEPTH)
        begin
            p_eff = CW'(WINDOW_DEPTH);
        end
        else
        begin
            p_eff = CW'(period_reg);
        end
        count_inc = (count_reg < CW'(WINDOW_DEPTH)) ? count_reg + CW'(1) : count_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        period_next    = cfg_write_en ? cfg_write_data : period_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        sum_next       = sum_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        range_next     = range_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        div_cnt_next   = div_cnt_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        smooth_next    = smooth_reg;
        prod_next      = prod_reg;
        fish_next      = fish_reg;
        fprev_next     = fprev_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        log_start      = 1'b0;

        range_w = max_reg - min_reg;
        num_w   = sum_reg - min_reg;
        rem_sh  = {rem_reg, 1'b0};
        qd      = $signed({1'b0, q_reg}) - fti_pkg::Q30_HALF;
        vsum    = pa_reg + pb_reg + 64'sd536870912;
        vsh     = vsum >>> 30;
        if (vsh > 64'(fti_pkg::K_099))
        begin
            vc = fti_pkg::K_0999;
        end
        else if (vsh < -64'(fti_pkg::K_099))
        begin
            vc = -fti_pkg::K_0999;
        end
        else
        begin
            vc = 32'(vsh);
        end
        opa_w  = 64'(fti_pkg::Q30_ONE) + 64'(vc);
        opb_w  = 64'(fti_pkg::Q30_ONE) - 64'(vc);
        opa    = 31'(opa_w);
        opb    = 31'(opb_w);
        d      = la - lb;
        at_w   = (prod_reg + 64'sd4294967296) >>> 33;
        half_w = (33'(fprev_reg) + 33'sd1) >>> 1;
        fish_w = 33'(at_w) + half_w;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_inc;
                    sum_next   = sum_in;
                    p_next     = p_eff;
                    if (count_inc < p_eff)
                    begin
                        wr_ptr_next = (wr_ptr_reg == AW'(WINDOW_DEPTH - 1)) ?
                                      '0 : wr_ptr_reg + AW'(1);
                    end
                    else
                    begin
                        max_next   = sum_in;
                        min_next   = sum_in;
                        k_next     = CW'(1);
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (k_reg < p_reg)
                begin
                    k_next    = k_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (rd_data > max_reg)
                    begin
                        max_next = rd_data;
                    end
                    if (rd_data < min_reg)
                    begin
                        min_next = rd_data;
                    end
                end
                if (k_reg >= p_reg && !pend_reg)
                begin
                    wr_ptr_next  = (wr_ptr_reg == AW'(WINDOW_DEPTH - 1)) ?
                                   '0 : wr_ptr_reg + AW'(1);
                    range_next   = range_w;
                    div_cnt_next = '0;
                    if (range_w == '0)
                    begin
                        q_next     = '0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        if (num_w >= range_w)
                        begin
                            q_next   = 31'd1;
                            rem_next = num_w - range_w;
                        end
                        else
                        begin
                            q_next   = 31'd0;
                            rem_next = num_w;
                        end
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, range_reg})
                begin
                    rem_next = W'(rem_sh - {1'b0, range_reg});
                    q_next   = {q_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = W'(rem_sh);
                    q_next   = {q_reg[29:0], 1'b0};
                end
                if (div_cnt_reg == 5'd29)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 5'd1;
                end
            end
            ST_MUL:
            begin
                pa_next    = fti_pkg::K_066 * qd;
                pb_next    = fti_pkg::K_067 * smooth_reg;
                state_next = ST_SMTH;
            end
            ST_SMTH:
            begin
                smooth_next = vc;
                log_start   = 1'b1;
                state_next  = ST_LOGW;
            end
            ST_LOGW:
            begin
                if (!busy_a && !busy_b)
                begin
                    prod_next  = d * fti_pkg::K_HALF_LN2;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                fish_next  = 32'(fish_w);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.fisher_value = fish_reg;
                    out_data_next.signal_value = fprev_reg;
                    fprev_next                 = fish_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= fti_pkg::PERIOD_RESET;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            smooth_reg    <= '0;
            fprev_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            smooth_reg    <= smooth_next;
            fprev_reg     <= fprev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        k_reg        <= k_next;
        sum_reg      <= sum_next;
        max_reg      <= max_next;
        min_reg      <= min_next;
        range_reg    <= range_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        div_cnt_reg  <= div_cnt_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        prod_reg     <= prod_next;
        fish_reg     <= fish_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW_DEPTH))
        else $error("sample count past window depth");

    a_smooth_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        smooth_reg <= fti_pkg::K_0999 && smooth_reg >= -fti_pkg::K_0999)
        else $error("smoothed value outside clamp");

    a_log_join: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOGW && !busy_a && !busy_b |=> state_reg == ST_FIN)
        else $error("log results not taken");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && (!out_valid_reg || !out_stall) |=>
        out_valid_reg && state_reg == ST_IDLE)
        else $error("result beat not loaded");

endmodule
